### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/efp_pkg.sv
// ----------------------------------------------------------------------------
// Envelope frame parser package
// Phase codes, status codes, constants, config type, byte tables and character class functions.
// ----------------------------------------------------------------------------
package efp_pkg;

    localparam int CommandBytesDefault  = 64;
    localparam int IdentityBytesDefault = 128;
    localparam int PrefixLen            = 10;

    typedef enum logic [6:0] {
        PH_MAGIC   = 7'b0000001,
        PH_FORM    = 7'b0000010,
        PH_LEN_HI  = 7'b0000100,
        PH_LEN_LO  = 7'b0001000,
        PH_CONTENT = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_ERROR   = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MALFORMED   = 3'd1,
        ST_UNSUPPORTED = 3'd2,
        ST_MISSING     = 3'd3,
        ST_TOO_LARGE   = 3'd4
    } status_t;

    localparam logic [1:0] CFG_MAX_FIELD = 2'd0;
    localparam logic [1:0] CFG_PLAIN     = 2'd1;
    localparam logic [1:0] CFG_ENCRYPTED = 2'd2;

    typedef struct packed {
        logic [15:0] max_field_bytes;
        logic [7:0]  plain_form_code;
        logic [7:0]  encrypted_form_code;
    } cfg_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                2'd0:    r = 8'h45;
                2'd1:    r = 8'h57;
                2'd2:    r = 8'h42;
                default: r = 8'h31;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                4'd0:    r = 8'h2f;
                4'd1:    r = 8'h7a;
                4'd2:    r = 8'h65;
                4'd3:    r = 8'h72;
                4'd4:    r = 8'h6f;
                4'd5:    r = 8'h63;
                4'd6:    r = 8'h6f;
                4'd7:    r = 8'h6e;
                4'd8:    r = 8'h66;
                default: r = 8'h2f;
            endcase
            return r;
        end
    endfunction

    function automatic logic is_cmd_char(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a)
            || (c >= 8'h61 && c <= 8'h7a) || c == 8'h2d || c == 8'h5f;
    endfunction

    function automatic logic is_id_char(input logic [7:0] c);
        return is_cmd_char(c) || c == 8'h2e;
    endfunction

endpackage

### hw/rtl/efp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module efp_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/efp_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the field length limit and the two form codes.
// ----------------------------------------------------------------------------
module efp_cfg_regs
    import efp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        cfg_ready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_field_bytes     <= 16'd1024;
            cfg_reg.plain_form_code     <= 8'd0;
            cfg_reg.encrypted_form_code <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MAX_FIELD: cfg_reg.max_field_bytes     <= cfg_data;
                CFG_PLAIN:     cfg_reg.plain_form_code     <= cfg_data[7:0];
                CFG_ENCRYPTED: cfg_reg.encrypted_form_code <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

### hw/rtl/envelope_frame_parser.sv
// Each result is registered in the output register when its byte is taken.
// Throughput: one byte per cycle while the output side is not stalled.
// The command compare reads the command store one byte early, so the data is ready for the compare.
// Reset clears the frame state and output valid and restores the register defaults.
// ----------------------------------------------------------------------------
// Envelope frame parser
// Parses envelope frames byte by byte and passes out field content with status.
// ----------------------------------------------------------------------------
module envelope_frame_parser
    import efp_pkg::*;
#(
    parameter int COMMAND_BYTES       = CommandBytesDefault,
    parameter int IDENTITY_PART_BYTES = IdentityBytesDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        content_valid,
    output logic [2:0]  field_number,
    output logic [7:0]  content_byte,
    output logic        field_end,
    output logic        frame_done,
    output logic [2:0]  frame_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

    localparam int AW = $clog2(COMMAND_BYTES);
    localparam int CLW = $clog2(COMMAND_BYTES + 1);

    cfg_t cfg;

    efp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic        enc_reg, enc_next;
    logic [2:0]  perr_reg, perr_next;
    logic [2:0]  verr_reg, verr_next;
    logic [CLW-1:0] clen_reg, clen_next;
    logic        pm_reg, pm_next;

    logic        ov_reg;
    logic        cv_reg, cv_next;
    logic [2:0]  fn_reg, fn_next;
    logic [7:0]  cb_reg, cb_next;
    logic        fe_reg, fe_next;
    logic        fd_reg;
    logic [2:0]  fs_reg, fs_next;

    logic        accept;
    logic        wr_en;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]  rd_data;
    logic [16:0] q_cur;
    logic [16:0] pos_inc;

    assign in_stall = ov_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // The store is read for the path byte that comes next.
    assign q_cur = {1'b0, pos_reg} - 17'(PrefixLen);

    efp_ram #(.Width(8), .Depth(COMMAND_BYTES)) u_cmd_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg[AW-1:0]),
        .wr_data (frame_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        logic [16:0] qn;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        fidx_next  = fidx_reg;
        enc_next   = enc_reg;
        perr_next  = perr_reg;
        verr_next  = verr_reg;
        clen_next  = clen_reg;
        pm_next    = pm_reg;
        cv_next    = 1'b0;
        fn_next    = 3'd0;
        cb_next    = 8'd0;
        fe_next    = 1'b0;
        fs_next    = ST_OK;
        wr_en      = 1'b0;
        pos_inc    = {1'b0, pos_reg} + 17'd1;
        qn         = pos_inc - 17'(PrefixLen);
        rd_en      = 1'b0;
        rd_addr    = qn[AW-1:0];

        if (accept)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (pos_reg > 16'd3 || frame_byte != magic_byte(pos_reg[1:0]))
                    begin
                        perr_next  = ST_MALFORMED;
                        phase_next = PH_ERROR;
                    end
                    else if (pos_reg == 16'd3)
                    begin
                        pos_next   = 16'd0;
                        phase_next = PH_FORM;
                    end
                    else
                    begin
                        pos_next = pos_inc[15:0];
                    end
                end
                PH_FORM:
                begin
                    if (frame_byte == cfg.plain_form_code)
                    begin
                        enc_next   = 1'b0;
                        phase_next = PH_LEN_HI;
                    end
                    else if (frame_byte == cfg.encrypted_form_code)
                    begin
                        enc_next   = 1'b1;
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        perr_next  = ST_UNSUPPORTED;
                        phase_next = PH_ERROR;
                    end
                end
                PH_LEN_HI:
                begin
                    len_next   = {frame_byte, 8'd0};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_next = {len_reg[15:8], frame_byte};
                    if (len_next == 16'd0)
                    begin
                        perr_next  = ST_MISSING;
                        phase_next = PH_ERROR;
                    end
                    else if (len_next > cfg.max_field_bytes)
                    begin
                        perr_next  = ST_TOO_LARGE;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        if (fidx_reg == 3'd1 || fidx_reg == 3'd2)
                        begin
                            if (len_next > 16'(IDENTITY_PART_BYTES))
                            begin
                                verr_next = ST_MISSING;
                            end
                        end
                        else if (fidx_reg == 3'd3)
                        begin
                            if (len_next > 16'(COMMAND_BYTES))
                            begin
                                verr_next = ST_MISSING;
                                clen_next = CLW'(COMMAND_BYTES);
                            end
                            else
                            begin
                                clen_next = len_next[CLW-1:0];
                            end
                        end
                        else if (fidx_reg == 3'd4)
                        begin
                            if ({1'b0, len_next} != 17'(PrefixLen) + 17'(clen_reg))
                            begin
                                pm_next = 1'b0;
                            end
                        end
                        pos_next   = 16'd0;
                        phase_next = PH_CONTENT;
                    end
                end
                PH_CONTENT:
                begin
                    cv_next = 1'b1;
                    fn_next = fidx_reg;
                    cb_next = frame_byte;
                    if (fidx_reg == 3'd1 || fidx_reg == 3'd2)
                    begin
                        if (!is_id_char(frame_byte))
                        begin
                            verr_next = ST_MISSING;
                        end
                    end
                    else if (fidx_reg == 3'd3)
                    begin
                        if (!is_cmd_char(frame_byte))
                        begin
                            verr_next = ST_MISSING;
                        end
                        wr_en = pos_reg < 16'(COMMAND_BYTES);
                    end
                    else if (fidx_reg == 3'd4)
                    begin
                        if (pos_reg < 16'(PrefixLen))
                        begin
                            if (frame_byte != prefix_byte(pos_reg[3:0]))
                            begin
                                pm_next = 1'b0;
                            end
                        end
                        else if (q_cur >= 17'(clen_reg) || q_cur >= 17'(COMMAND_BYTES)
                                 || rd_data != frame_byte)
                        begin
                            pm_next = 1'b0;
                        end
                        rd_en = pos_inc >= 17'(PrefixLen);
                    end
                    if (pos_inc >= {1'b0, len_reg})
                    begin
                        fe_next    = 1'b1;
                        pos_next   = 16'd0;
                        fidx_next  = fidx_reg + 3'd1;
                        if ((enc_reg && fidx_reg == 3'd7) || (!enc_reg && fidx_reg == 3'd6))
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                    else
                    begin
                        pos_next = pos_inc[15:0];
                    end
                end
                PH_DONE:
                begin
                    perr_next  = ST_MALFORMED;
                    phase_next = PH_ERROR;
                end
                PH_ERROR:
                begin
                end
                default:
                begin
                end
            endcase

            if (frame_last)
            begin
                if (perr_next != ST_OK)
                begin
                    fs_next = perr_next;
                end
                else if (phase_next != PH_DONE)
                begin
                    fs_next = ST_MALFORMED;
                end
                else if (verr_next != ST_OK)
                begin
                    fs_next = verr_next;
                end
                else if (!pm_next)
                begin
                    fs_next = ST_MALFORMED;
                end
                phase_next = PH_MAGIC;
                pos_next   = 16'd0;
                len_next   = 16'd0;
                fidx_next  = 3'd0;
                enc_next   = 1'b0;
                perr_next  = ST_OK;
                verr_next  = ST_OK;
                clen_next  = '0;
                pm_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= 16'd0;
            len_reg   <= 16'd0;
            fidx_reg  <= 3'd0;
            enc_reg   <= 1'b0;
            perr_reg  <= ST_OK;
            verr_reg  <= ST_OK;
            clen_reg  <= '0;
            pm_reg    <= 1'b1;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            fidx_reg  <= fidx_next;
            enc_reg   <= enc_next;
            perr_reg  <= perr_next;
            verr_reg  <= verr_next;
            clen_reg  <= clen_next;
            pm_reg    <= pm_next;
            if (accept)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cv_reg <= cv_next;
            fn_reg <= fn_next;
            cb_reg <= cb_next;
            fe_reg <= fe_next;
            fd_reg <= frame_last;
            fs_reg <= fs_next;
        end
    end

    assign out_valid     = ov_reg;
    assign content_valid = cv_reg;
    assign field_number  = fn_reg;
    assign content_byte  = cb_reg;
    assign field_end     = fe_reg;
    assign frame_done    = fd_reg;
    assign frame_status  = fs_reg;

    `ASSERT_NEXT(a_last_resets, clk, rst_n, accept && frame_last, phase_reg == PH_MAGIC)
    `ASSERT_IMPLIES(a_end_has_content, clk, rst_n, ov_reg && fe_reg, cv_reg)
    `ASSERT_IMPLIES(a_status_on_done, clk, rst_n, ov_reg && !fd_reg, fs_reg == ST_OK)
    `ASSERT_IMPLIES(a_error_latched, clk, rst_n, phase_reg == PH_ERROR, perr_reg != ST_OK)

endmodule
